[rtl/linear_probe_hash_table_assert.svh]
// Assertion macros used by the hash table RTL.
// Each macro expects clk and arst_n in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LPHT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps
package lpht_pkg;

	// Field widths
	localparam int OPCODE_W     = 2;
	localparam int KEY_W        = 31;
	localparam int VAL_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int SLOT_IDX_W   = 6;
	localparam int ENTRIES_W    = 7;
	localparam int MARK_W       = 2;

	localparam int TABLE_ENTRIES_DEF = 64;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

	// Result status
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	// Slot marks
	localparam logic [MARK_W-1:0] MARK_NEVER = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	// One table slot as stored in RAM
	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  val;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

[rtl/lpht_ram.sv]
`timescale 1ns / 1ps
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// Channel  Handshake            Fields
// in       in_valid / in_ready   opcode, lookup_key, payload
// out      out_valid / out_ready status, slot_index, payload_out, entries_used
//
// After reset a clearing pass marks every slot never used, with in_ready low.
// Power-of-two tables probe k slots from the home slot, k from 1 to TABLE_ENTRIES.
// Other sizes first compute the home slot remainder in S_HASH (reciprocal multiply, back-multiply, subtract).
// The probe rate is one slot per cycle, set by the single read port of the slot RAM.
// One transaction at a time; a result waiting on out_ready holds the next one in its final cycle.
module linear_probe_hash_table #(
	parameter int TABLE_ENTRIES = lpht_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lpht_pkg::OPCODE_W-1:0]     opcode,
	input  logic [lpht_pkg::KEY_W-1:0]        lookup_key,
	input  logic [lpht_pkg::VAL_W-1:0]        payload,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lpht_pkg::STATUS_W-1:0]     status,
	output logic [lpht_pkg::SLOT_IDX_W-1:0]   slot_index,
	output logic [lpht_pkg::VAL_W-1:0]        payload_out,
	output logic [lpht_pkg::ENTRIES_W-1:0]    entries_used
);

	import lpht_pkg::*;

	`include "linear_probe_hash_table_assert.svh"

	localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW   = AW + 1;
	localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
	localparam logic [AW-1:0]   LAST_SLOT = AW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0]   ENTRIES_C = CW'(TABLE_ENTRIES);

	// Reciprocal of the table size, exact for every 31-bit key
	localparam int HOME_SH = KEY_W + AW;
	localparam longint unsigned HOME_MUL_L =
		((64'd1 << HOME_SH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
	localparam logic [31:0] HOME_MUL   = 32'(HOME_MUL_L);
	localparam logic [1:0]  HSTEP_LAST = 2'd2;

	// Sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	// Probe outcome
	localparam logic [1:0] RES_HIT   = 2'd0;
	localparam logic [1:0] RES_NEVER = 2'd1;
	localparam logic [1:0] RES_FULL  = 2'd2;

	logic [2:0]          state_q;
	logic [AW-1:0]       ptr_q;
	logic [AW-1:0]       chk_ptr_q;
	logic                chk_v_q;
	logic [CW-1:0]       left_q;
	logic [CW-1:0]       pend_q;
	logic [1:0]          hstep_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;

	logic [OPCODE_W-1:0] op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [KEY_W+31:0]   hprod_q;
	logic [KEY_W+CW-1:0] hqn_q;
	logic [1:0]          res_q;
	logic [AW-1:0]       res_addr_q;
	logic [VAL_W-1:0]    hit_pay_q;

	logic [STATUS_W-1:0] status_q;
	logic [AW-1:0]       slot_q;
	logic [VAL_W-1:0]    pout_q;

	// RAM ports
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	slot_t               ram_wdata;
	logic [SLOT_W-1:0]   ram_rdata;
	slot_t               rd;

	// Combinational helpers
	logic [KEY_W-1:0]    hquot;
	logic [KEY_W+CW-1:0] hqn_next;
	logic [KEY_W-1:0]    hrem;
	logic [AW-1:0]       ptr_inc;
	logic                chk_never;
	logic                chk_hit;
	logic                chk_last;
	logic                probe_stop;
	logic                issue;
	logic                out_load;
	logic [STATUS_W-1:0] fin_status;
	logic                fin_ok;
	logic [VAL_W-1:0]    fin_pout;
	logic [CW-1:0]       fin_cnt;
	logic                fin_we;
	slot_t               fin_wdata;
	logic [AW+SLOT_IDX_W-1:0] slot_ext;
	logic [CW+ENTRIES_W-1:0]  cnt_ext;

	lpht_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign rd = slot_t'(ram_rdata);

	// Home slot for other sizes: quotient by reciprocal multiply, then remainder
	assign hquot    = KEY_W'(hprod_q >> HOME_SH);
	assign hqn_next = hquot * ENTRIES_C;
	assign hrem     = key_q - KEY_W'(hqn_q);

	// Probe address walk with wrap
	assign ptr_inc = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;

	// Probe check on the slot read last cycle
	assign chk_never  = chk_v_q && (rd.mark == MARK_NEVER);
	assign chk_hit    = chk_v_q && (rd.mark == MARK_LIVE) && (rd.key == key_q);
	assign chk_last   = chk_v_q && (pend_q == CW'(1));
	assign probe_stop = chk_never || chk_hit || chk_last;
	assign issue      = (state_q == S_PROBE) && (left_q != '0) && !probe_stop;

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Final decision per opcode and probe outcome
	always_comb begin
		fin_status = ST_ABSENT;
		fin_ok     = 1'b0;
		fin_pout   = '0;
		fin_cnt    = cnt_q;
		fin_we     = 1'b0;
		fin_wdata  = '{mark: MARK_LIVE, key: key_q, val: val_q};
		unique case (op_q)
			OP_INSERT: begin
				if (res_q == RES_FULL) begin
					fin_status = ST_FULL;
				end else begin
					fin_status = ST_OK;
					fin_ok     = 1'b1;
					fin_we     = 1'b1;
					if (res_q == RES_NEVER) begin
						fin_cnt = cnt_q + 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (res_q == RES_HIT) begin
					fin_status = ST_OK;
					fin_ok     = 1'b1;
					fin_we     = 1'b1;
					fin_wdata  = '{mark: MARK_TOMB, key: key_q, val: hit_pay_q};
					if (cnt_q != '0) begin
						fin_cnt = cnt_q - 1'b1;
					end
				end
			end
			OP_FIND: begin
				if (res_q == RES_HIT) begin
					fin_status = ST_OK;
					fin_ok     = 1'b1;
					fin_pout   = hit_pay_q;
				end
			end
			default: begin
				fin_status = ST_ABSENT;
			end
		endcase
	end

	// RAM write: clearing pass or final write-back
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = '{mark: MARK_NEVER, key: '0, val: '0};
		end else begin
			ram_we    = out_load && fin_we;
			ram_waddr = res_addr_q;
			ram_wdata = fin_wdata;
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			chk_v_q     <= 1'b0;
			left_q      <= '0;
			pend_q      <= '0;
			hstep_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_inc;
					if (ptr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						left_q  <= ENTRIES_C;
						pend_q  <= ENTRIES_C;
						hstep_q <= '0;
						chk_v_q <= 1'b0;
						if (IS_POW2) begin
							ptr_q   <= lookup_key[AW-1:0];
							state_q <= S_PROBE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					hstep_q <= hstep_q + 1'b1;
					if (hstep_q == HSTEP_LAST) begin
						ptr_q   <= hrem[AW-1:0];
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					chk_v_q <= issue;
					if (issue) begin
						ptr_q  <= ptr_inc;
						left_q <= left_q - 1'b1;
					end
					if (chk_v_q) begin
						pend_q <= pend_q - 1'b1;
					end
					if (probe_stop) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						cnt_q   <= fin_cnt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			op_q  <= opcode;
			key_q <= lookup_key;
			val_q <= payload;
		end
		if (state_q == S_HASH) begin
			hprod_q <= key_q * HOME_MUL;
			hqn_q   <= hqn_next;
		end
		if (state_q == S_PROBE) begin
			chk_ptr_q <= ptr_q;
			if (probe_stop) begin
				res_addr_q <= chk_ptr_q;
				hit_pay_q  <= rd.val;
				if (chk_hit) begin
					res_q <= RES_HIT;
				end else if (chk_never) begin
					res_q <= RES_NEVER;
				end else begin
					res_q <= RES_FULL;
				end
			end
		end
		if (out_load) begin
			status_q <= fin_status;
			slot_q   <= fin_ok ? res_addr_q : '0;
			pout_q   <= fin_pout;
		end
	end

	assign slot_ext = {{SLOT_IDX_W{1'b0}}, slot_q};
	assign cnt_ext  = {{ENTRIES_W{1'b0}}, cnt_q};

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot_index   = slot_ext[SLOT_IDX_W-1:0];
	assign payload_out  = pout_q;
	assign entries_used = cnt_ext[ENTRIES_W-1:0];

	// Checks
	`LPHT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, (state_q == S_PROBE) || (state_q == S_HASH), "accepted transaction did not start a probe or hash")
	`LPHT_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= ENTRIES_C, "live count exceeds table size")
	`LPHT_ASSERT_SAME(a_chk_in_probe, chk_v_q, state_q == S_PROBE, "pending slot check outside probe")
	`LPHT_ASSERT_SAME(a_we_phase, ram_we, (state_q == S_CLEAR) || (state_q == S_FIN), "slot RAM written outside clear or write-back")
	`LPHT_ASSERT_NEXT(a_cnt_hold, !out_load, $stable(cnt_q), "live count changed without a result")

endmodule
